/* design/rlsu_pkg.sv */
// ----------------------------------------------------------------------------
// rlsu_pkg
// Shared types and constants for the ring lattice two-species update block.
// ----------------------------------------------------------------------------
package rlsu_pkg;

    // Ring size and derived widths
    localparam int LATTICE_SIZE = 128;
    localparam int ADDR_W       = (LATTICE_SIZE > 1) ? $clog2(LATTICE_SIZE) : 1;
    localparam int CNT_W        = $clog2(LATTICE_SIZE + 1);

    // Field widths
    localparam int CELL_W  = 7;
    localparam int DRAW_W  = 16;
    localparam int GAMMA_W = 18;
    localparam int COUNT_W = 8;

    // Index compare width: holds any field index and LATTICE_SIZE itself
    localparam int IDX_W = (ADDR_W > CELL_W) ? ADDR_W : CELL_W;
    localparam int CMP_W = IDX_W + 1;

    // Arithmetic widths for the probability tests
    localparam int GA_W  = CNT_W + GAMMA_W;
    localparam int SUM_W = GA_W + 1;

    localparam int ONE_Q16 = 65536;
    localparam int FULL_SCALE = LATTICE_SIZE * ONE_Q16;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(ONE_Q16);

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [CELL_W-1:0]  cell_index;
        logic               load_value;
        logic [DRAW_W-1:0]  draw_spread;
        logic               step_right;
        logic [CELL_W-1:0]  target_site;
        logic [DRAW_W-1:0]  draw_convert;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count_a;
        logic [COUNT_W-1:0] count_b;
        logic               site_flipped;
        logic               absorbed;
    } t_out_item;

endpackage

/* design/rlsu_in_if.sv */
// ----------------------------------------------------------------------------
// rlsu_in_if
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface rlsu_in_if;
    import rlsu_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/rlsu_out_if.sv */
// ----------------------------------------------------------------------------
// rlsu_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface rlsu_out_if;
    import rlsu_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/rlsu_cfg_if.sv */
// ----------------------------------------------------------------------------
// rlsu_cfg_if
// Valid/ready write channel for the gamma register.
// ----------------------------------------------------------------------------
interface rlsu_cfg_if;
    import rlsu_pkg::*;

    logic               valid;
    logic               ready;
    logic [GAMMA_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ring_lattice_two_species_update.sv */
// ----------------------------------------------------------------------------
// ring_lattice_two_species_update
// Ring of A/B sites with load and Monte Carlo spread/convert update items.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result register is full and not read, and
// returns one result per item, in order. An item accepted at a clock edge is
// evaluated in the execute stage and its result is registered when that stage
// fires. The rate is set by the execute stage: the A count and the site values
// written by one item feed the next item's tests in the very next cycle, closed
// by one 8x18 multiply, one compare and a +/-1 on the count, with a bypass from
// the site write port to the reads. Sites live in three copies of a 1-bit RAM
// (agent, neighbor, target reads) plus one valid flop per site, so the ring reads
// as all B right after reset with no clearing pass. The output register decouples
// the two sides: a new item enters an empty execute stage while a finished result
// waits. gamma is written through its own channel, always ready, and must only
// change while the block is idle.
// ----------------------------------------------------------------------------
module ring_lattice_two_species_update (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlsu_cfg_if.sink   i_cfg,
    rlsu_in_if.sink    i_item,
    rlsu_out_if.source o_result
);
    import rlsu_pkg::*;

    // ------------------------------------------------------------------
    // Handshake / pipeline control
    // ------------------------------------------------------------------
    logic r_e_valid;    // item sitting in execute stage
    logic r_out_valid;  // result register full
    logic fire;         // execute stage completes this cycle
    logic in_accept;

    assign fire          = r_e_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready  = !r_e_valid || fire;
    assign in_accept     = i_item.valid && i_item.ready;
    assign i_cfg.ready   = 1'b1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [GAMMA_W-1:0] r_gamma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_gamma <= i_cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // Read address generation for the incoming item
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]  in_cell;
    logic [CMP_W-1:0]  in_tgt;
    logic [CMP_W-1:0]  in_nb;
    logic [ADDR_W-1:0] rd_agent_addr;
    logic [ADDR_W-1:0] rd_nb_addr;
    logic [ADDR_W-1:0] rd_tgt_addr;

    always_comb begin
        in_cell = CMP_W'(i_item.data.cell_index);
        in_tgt  = CMP_W'(i_item.data.target_site);
        // ring wrap on the neighbor
        if (i_item.data.step_right) begin
            in_nb = (in_cell + 1'b1 == CMP_W'(LATTICE_SIZE)) ? '0 : in_cell + 1'b1;
        end else begin
            in_nb = (in_cell == '0) ? CMP_W'(LATTICE_SIZE - 1) : in_cell - 1'b1;
        end
        rd_agent_addr = ADDR_W'(in_cell);
        rd_nb_addr    = ADDR_W'(in_nb);
        rd_tgt_addr   = ADDR_W'(in_tgt);
    end

    // ------------------------------------------------------------------
    // Site storage: three read copies, one shared write port
    // ------------------------------------------------------------------
    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    logic              w_data;
    logic              ram_agent_q;
    logic              ram_nb_q;
    logic              ram_tgt_q;

    rlsu_ram #(.WIDTH(1), .DEPTH(LATTICE_SIZE)) u_ram_agent (
        .i_clk     (i_clk),
        .i_wr_en   (w_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_agent_addr),
        .o_rd_data (ram_agent_q)
    );

    rlsu_ram #(.WIDTH(1), .DEPTH(LATTICE_SIZE)) u_ram_nb (
        .i_clk     (i_clk),
        .i_wr_en   (w_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_nb_addr),
        .o_rd_data (ram_nb_q)
    );

    rlsu_ram #(.WIDTH(1), .DEPTH(LATTICE_SIZE)) u_ram_tgt (
        .i_clk     (i_clk),
        .i_wr_en   (w_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_tgt_addr),
        .o_rd_data (ram_tgt_q)
    );

    // Per-site written flags; an unwritten site reads as B.
    logic [LATTICE_SIZE-1:0] r_site_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_valid <= '0;
        end else if (w_en) begin
            r_site_valid[w_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Execute-stage item registers
    // ------------------------------------------------------------------
    t_in_item          r_item;
    logic [ADDR_W-1:0] r_agent_addr;
    logic [ADDR_W-1:0] r_nb_addr;
    logic [ADDR_W-1:0] r_tgt_addr;
    logic              r_cell_ok;
    logic              r_tgt_ok;
    logic              r_vld_agent;
    logic              r_vld_nb;
    logic              r_vld_tgt;
    logic              r_byp_agent;   // read collided with the write at that edge
    logic              r_byp_nb;
    logic              r_byp_tgt;
    logic              r_byp_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (in_accept) begin
            r_e_valid <= 1'b1;
        end else if (fire) begin
            r_e_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item       <= i_item.data;
            r_agent_addr <= rd_agent_addr;
            r_nb_addr    <= rd_nb_addr;
            r_tgt_addr   <= rd_tgt_addr;
            r_cell_ok    <= in_cell < CMP_W'(LATTICE_SIZE);
            r_tgt_ok     <= in_tgt < CMP_W'(LATTICE_SIZE);
            r_vld_agent  <= r_site_valid[rd_agent_addr];
            r_vld_nb     <= r_site_valid[rd_nb_addr];
            r_vld_tgt    <= r_site_valid[rd_tgt_addr];
            r_byp_agent  <= w_en && (w_addr == rd_agent_addr);
            r_byp_nb     <= w_en && (w_addr == rd_nb_addr);
            r_byp_tgt    <= w_en && (w_addr == rd_tgt_addr);
            r_byp_data   <= w_data;
        end
    end

    // ------------------------------------------------------------------
    // Execute: site values, probability tests, single site write
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             agent_v;
    logic             nb_v;
    logic             tgt_v;
    logic [GA_W-1:0]  ga;
    logic [GA_W-1:0]  spread_lhs;
    logic [SUM_W-1:0] convert_lhs;
    logic             spread_ok;
    logic             convert_ok;

    assign agent_v = r_byp_agent ? r_byp_data : (r_vld_agent && ram_agent_q);
    assign nb_v    = r_byp_nb    ? r_byp_data : (r_vld_nb    && ram_nb_q);
    assign tgt_v   = r_byp_tgt   ? r_byp_data : (r_vld_tgt   && ram_tgt_q);

    // (L - countA) * gamma, both sides non-negative
    assign ga = GA_W'(CNT_W'(LATTICE_SIZE) - r_count) * GA_W'(r_gamma);

    // draw_spread * L < ga
    assign spread_lhs = GA_W'(r_item.draw_spread) * GA_W'(LATTICE_SIZE);
    assign spread_ok  = spread_lhs < ga;

    // draw_convert * L < L*65536 - ga, rearranged to stay unsigned
    assign convert_lhs = SUM_W'(GA_W'(r_item.draw_convert) * GA_W'(LATTICE_SIZE))
                       + SUM_W'(ga);
    assign convert_ok  = convert_lhs < SUM_W'(FULL_SCALE);

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_agent_addr;
        w_data = r_item.load_value;
        if (fire && r_cell_ok) begin
            unique case (r_item.func)
                FUNC_LOAD: begin
                    w_en = (agent_v != r_item.load_value);
                end
                FUNC_STEP: begin
                    if (agent_v) begin
                        // A agent spreads onto a B neighbor
                        w_addr = r_nb_addr;
                        w_data = 1'b1;
                        w_en   = spread_ok && !nb_v;
                    end else begin
                        // B agent converts an A target
                        w_addr = r_tgt_addr;
                        w_data = 1'b0;
                        w_en   = r_tgt_ok && convert_ok && tgt_v;
                    end
                end
                default: begin
                    w_en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_en) begin
            n_count = w_data ? r_count + 1'b1 : r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (fire) begin
            r_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data.count_a      <= COUNT_W'(n_count);
            r_out_data.count_b      <= COUNT_W'(CNT_W'(LATTICE_SIZE) - n_count);
            r_out_data.site_flipped <= w_en;
            r_out_data.absorbed     <= (n_count == '0) ||
                                       (n_count == CNT_W'(LATTICE_SIZE));
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A flip moves the A count by exactly one.
    a_flip_moves_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && w_en |=> (r_count == $past(r_count) + 1'b1) ||
                         (r_count == $past(r_count) - 1'b1))
        else $error("A count did not move by one on a site flip");

    // Without a flip the A count holds.
    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !(fire && w_en) |=> $stable(r_count))
        else $error("A count changed without a site flip");

    // Input stalls only when execute is occupied and the result slot is full.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> r_e_valid && r_out_valid)
        else $error("input stalled with room in the pipeline");

    // A completed item always lands in the result register.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("executed item produced no result");

endmodule

/* design/rlsu_ram.sv */
// ----------------------------------------------------------------------------
// rlsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlsu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
